// ===== rtl/mafp_pkg.sv =====
// Package for the multi-axis flight PID core: payload structs, register
// indexes, controller states, command and status structs. No dependencies.
`default_nettype none
package mafp_pkg;

  localparam int GAIN_FRAC = 24;
  localparam int NUM_AXES  = 3;

  typedef struct packed {
    logic [1:0]         axis;
    logic signed [15:0] stick;
    logic signed [23:0] gyro_rate;
    logic signed [23:0] attitude_angle;
    logic               throttle_zero;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         axis_out;
    logic signed [15:0] drive;
    logic signed [15:0] p_term;
    logic signed [15:0] i_term;
    logic signed [15:0] d_term;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_FLIGHT_MODE = 3'd0,
    REG_PROP_GAINS  = 3'd1,
    REG_INTEG_GAINS = 3'd2,
    REG_DERIV_GAINS = 3'd3,
    REG_RATE_LIMITS = 3'd4,
    REG_ANGLE_SET   = 3'd5,
    REG_INTEG_LIMIT = 3'd6,
    REG_FILT_ALPHA  = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_RATE   = 3'd0,
    MODE_ANGLE  = 3'd1,
    MODE_FBWA   = 3'd2,
    MODE_PROLL  = 3'd3,
    MODE_MANUAL = 3'd4
  } flight_mode_t;

  typedef enum logic [1:0] {
    CTL_PASS  = 2'd0,
    CTL_RATE  = 2'd1,
    CTL_ANGLE = 2'd2
  } ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SP1, ST_SP2, ST_ERR, ST_P, ST_I, ST_D, ST_F, ST_SUM, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic sp1;
    logic sp2;
    logic err;
    logic p;
    logic i;
    logic d;
    logic f;
    logic sum;
  } cmd_t;

  typedef struct packed {
    ctl_t ctl;
  } status_t;

  function automatic ctl_t mode_ctl(input logic [2:0] mode, input logic [1:0] axis);
    ctl_t c;
    c = CTL_PASS;
    if (axis < 2'(NUM_AXES) && axis != 2'd3) begin
      case (mode)
        MODE_RATE:  c = CTL_RATE;
        MODE_ANGLE: c = (axis == 2'd2) ? CTL_RATE : CTL_ANGLE;
        MODE_FBWA:  c = (axis == 2'd2) ? CTL_PASS : CTL_ANGLE;
        MODE_PROLL: c = (axis == 2'd0) ? CTL_ANGLE : CTL_PASS;
        default:    c = CTL_PASS;
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mafp_ctrl.sv =====
// Controller state machine for the flight PID core.
// Depends on mafp_pkg; drives mafp_datapath through cmd_t.
`default_nettype none
module mafp_ctrl
  import mafp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SP1;
        end
      end
      ST_SP1: begin
        cmd.sp1 = 1'b1;
        if (status.ctl == CTL_PASS) state_nxt = ST_SUM;
        else if (status.ctl == CTL_ANGLE) state_nxt = ST_SP2;
        else state_nxt = ST_ERR;
      end
      ST_SP2: begin cmd.sp2 = 1'b1; state_nxt = ST_ERR; end
      ST_ERR: begin cmd.err = 1'b1; state_nxt = ST_P; end
      ST_P:   begin cmd.p = 1'b1; state_nxt = ST_I; end
      ST_I:   begin cmd.i = 1'b1; state_nxt = ST_D; end
      ST_D:   begin cmd.d = 1'b1; state_nxt = ST_F; end
      ST_F:   begin cmd.f = 1'b1; state_nxt = ST_SUM; end
      ST_SUM: begin cmd.sum = 1'b1; state_nxt = ST_OUT; end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == ST_IDLE) else $error("load outside idle");
  a_out_follows_sum: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum |=> out_valid) else $error("result not presented after sum");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
endmodule
`default_nettype wire

// ===== rtl/mafp_datapath.sv =====
// Datapath of the flight PID core: config registers, per-axis state, one
// shared multiplier. Depends on mafp_pkg; sequenced by mafp_ctrl.
`default_nettype none
module mafp_datapath
  import mafp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [47:0] cfg_wdata,
  input  wire in_item_t    in_item,
  input  wire cmd_t        cmd,
  output status_t          status,
  output out_item_t        out_item
);
  logic [2:0]  mode_r;
  logic [47:0] kp_r, ki_r, kd_r, rlim_r, aset_r;
  logic [14:0] ilim_r;
  logic [15:0] alpha_r;

  logic signed [15:0] integ_r [NUM_AXES];
  logic signed [23:0] lerr_r  [NUM_AXES];
  logic signed [23:0] dfilt_r [NUM_AXES];

  in_item_t           it_r;
  ctl_t               ctl_r;
  logic signed [47:0] acc_r;
  logic signed [23:0] err_r;
  logic signed [15:0] p_r, i_r, d_r, drv_r;

  logic [1:0]  ax;
  logic [15:0] kp_s, ki_s, kd_s, rl_s, al_s, mult_s;
  assign ax = it_r.axis;
  assign kp_s   = kp_r[16*ax[1:0] +: 16];
  assign ki_s   = ki_r[16*ax[1:0] +: 16];
  assign kd_s   = kd_r[16*ax[1:0] +: 16];
  assign rl_s   = rlim_r[16*ax[1:0] +: 16];
  assign al_s   = aset_r[16*ax[0] +: 16];
  assign mult_s = aset_r[47:32];

  logic [$clog2(NUM_AXES+1)-1:0] axi;
  logic                          ax_ok;
  assign ax_ok = ax < 2'(NUM_AXES) && ax != 2'd3;
  assign axi   = ax_ok ? ($bits(axi))'(ax) : '0;

  // shared multiplier: signed 33 x unsigned 16
  logic signed [32:0] mul_a;
  logic        [15:0] mul_b;
  logic signed [49:0] mul_y;
  logic signed [25:0] sp_ang;
  logic signed [24:0] diff_e, diff_d;
  logic signed [48:0] sp_full;
  logic signed [24:0] errw;

  assign sp_ang = 26'(acc_r >>> 7) - 26'(it_r.attitude_angle);
  assign diff_e = 25'(err_r) - 25'(lerr_r[axi]);
  assign diff_d = 25'($signed(acc_r[23:0])) - 25'(dfilt_r[axi]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.sp1) begin
      mul_a = 33'(it_r.stick);
      mul_b = (ctl_r == CTL_ANGLE) ? al_s : rl_s;
    end else if (cmd.sp2) begin
      mul_a = 33'(sp_ang);
      mul_b = mult_s;
    end else if (cmd.p) begin
      mul_a = 33'(err_r); mul_b = kp_s;
    end else if (cmd.i) begin
      mul_a = 33'(err_r); mul_b = ki_s;
    end else if (cmd.d) begin
      mul_a = 33'(diff_e); mul_b = kd_s;
    end else if (cmd.f) begin
      mul_a = 33'(diff_d); mul_b = alpha_r;
    end
  end
  assign mul_y = mul_a * $signed({1'b0, mul_b});

  function automatic logic signed [15:0] sat16(input logic signed [49:0] x);
    if (x > 50'sd32767) return 16'sh7fff;
    if (x < -50'sd32768) return 16'sh8000;
    return x[15:0];
  endfunction
  function automatic logic signed [23:0] sat24(input logic signed [49:0] x);
    if (x > 50'sd8388607) return 24'sh7fffff;
    if (x < -50'sd8388608) return 24'sh800000;
    return x[23:0];
  endfunction

  logic signed [49:0] shf, inew, sum3, dnew;
  logic signed [15:0] ilim16;
  assign ilim16 = 16'(ilim_r);
  assign shf  = mul_y >>> GAIN_FRAC;
  assign sp_full = (ctl_r == CTL_ANGLE) ? 49'(acc_r) : 49'(acc_r >>> 7);
  assign errw = 25'(sat24(50'(sp_full) - 50'(it_r.gyro_rate)));
  assign inew = 50'(integ_r[axi]) + shf;
  assign dnew = 50'(dfilt_r[axi]) + (mul_y >>> 16);
  assign sum3 = 50'(p_r) + 50'(i_r) + 50'(d_r);

  assign status.ctl = ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RATE;
      kp_r <= '0; ki_r <= '0; kd_r <= '0; rlim_r <= '0; aset_r <= '0;
      ilim_r <= 15'd3277;
      alpha_r <= 16'hffff;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FLIGHT_MODE: if (cfg_wdata[2:0] <= MODE_MANUAL) mode_r <= cfg_wdata[2:0];
        REG_PROP_GAINS:  kp_r <= cfg_wdata;
        REG_INTEG_GAINS: ki_r <= cfg_wdata;
        REG_DERIV_GAINS: kd_r <= cfg_wdata;
        REG_RATE_LIMITS: rlim_r <= cfg_wdata;
        REG_ANGLE_SET:   aset_r <= cfg_wdata;
        REG_INTEG_LIMIT: ilim_r <= cfg_wdata[14:0];
        REG_FILT_ALPHA:  alpha_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        integ_r[a] <= '0; lerr_r[a] <= '0; dfilt_r[a] <= '0;
      end
    end else begin
      if (cmd.load && in_item.throttle_zero)
        for (int a = 0; a < NUM_AXES; a++) integ_r[a] <= '0;
      if (cmd.sp1 && ctl_r == CTL_PASS && ax_ok) integ_r[axi] <= '0;
      if (cmd.i) begin
        if (inew > 50'(ilim16)) integ_r[axi] <= ilim16;
        else if (inew < -50'(ilim16)) integ_r[axi] <= -ilim16;
        else integ_r[axi] <= inew[15:0];
      end
      if (cmd.f) begin
        dfilt_r[axi] <= dnew[23:0];
        lerr_r[axi]  <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r  <= in_item;
      ctl_r <= mode_ctl(mode_r, in_item.axis);
    end
    if (cmd.sp1 || cmd.sp2) acc_r <= mul_y[47:0];
    if (cmd.sp1 && ctl_r == CTL_PASS) begin
      p_r <= '0; i_r <= '0; d_r <= '0; drv_r <= it_r.stick;
    end
    if (cmd.err) err_r <= errw[23:0];
    if (cmd.p) p_r <= sat16(shf);
    if (cmd.i) begin
      if (inew > 50'(ilim16)) i_r <= ilim16;
      else if (inew < -50'(ilim16)) i_r <= -ilim16;
      else i_r <= inew[15:0];
    end
    if (cmd.d) acc_r <= 48'(sat24(shf));
    if (cmd.f) d_r <= sat16(dnew);
    if (cmd.sum && ctl_r != CTL_PASS) drv_r <= sat16(sum3);
  end

  assign out_item.axis_out = it_r.axis;
  assign out_item.drive    = drv_r;
  assign out_item.p_term   = p_r;
  assign out_item.i_term   = i_r;
  assign out_item.d_term   = d_r;

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.i |=> (integ_r[$past(axi)] <= ilim16) && (integ_r[$past(axi)] >= -ilim16))
    else $error("integrator outside clamp");
  a_pass_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum && ctl_r == CTL_PASS |-> p_r == 0 && i_r == 0 && d_r == 0)
    else $error("passthrough terms not zero");
  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= MODE_MANUAL) else $error("flight mode out of range");
endmodule
`default_nettype wire

// ===== rtl/multi_axis_flight_pid_core.sv =====
// Top level of the multi-axis flight PID core.
// Depends on mafp_pkg, mafp_ctrl and mafp_datapath.
// One axis sample in, one result out. A rate-controlled axis passes through the
// setpoint, error, P, I, D, filter and sum steps on one shared 33x16 multiplier
// before it presents its result; angle mode adds the setpoint scaling step, and a
// passthrough axis goes from setpoint straight to sum. After the result transfer
// the core returns to idle before the next sample is taken. One sample is worked
// on at a time.
`default_nettype none
module multi_axis_flight_pid_core
  import mafp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  mafp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .status, .cmd
  );

  mafp_datapath u_dp (
    .clk, .rst_n,
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
    .in_item(in_data), .cmd, .status, .out_item(out_data)
  );
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the multi-axis flight PID core.
// Depends on mafp_pkg and the RTL top level multi_axis_flight_pid_core.
// Predicts each result in fixed point and compares every field as it arrives.
`timescale 1ns / 1ps
module testbench;
  import mafp_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_t    cfg_index = REG_FLIGHT_MODE;
  logic [47:0] cfg_data = '0;

  multi_axis_flight_pid_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // controller copy: registers and per-axis state
  logic [2:0]  m_mode;
  logic [47:0] m_kp, m_ki, m_kd, m_rates, m_angles;
  longint      m_ilim, m_alpha;
  longint      m_integ [3];
  longint      m_last_err [3];
  longint      m_dfilt [3];

  in_item_t    samples_q [$];
  out_item_t   pid_results_q [$];
  int          errors = 0;
  int          n_samples = 0;
  int          n_results = 0;
  int          n_cfg = 0;
  int          n_pass = 0;
  int          rx_hold = 0;
  bit          tx_hold = 1'b0;
  bit          steady = 1'b0;
  int          quiet_cycles = 0;

  function automatic longint sat_to(longint x, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
  endfunction

  function automatic longint gain16(logic [47:0] r, int idx);
    return longint'(r[16*idx +: 16]);
  endfunction

  function automatic ctl_t axis_law(logic [2:0] mode, logic [1:0] axis);
    if (axis >= 2'(NUM_AXES) || axis == 2'd3) return CTL_PASS;
    case (mode)
      MODE_RATE:  return CTL_RATE;
      MODE_ANGLE: return axis == 2'd2 ? CTL_RATE : CTL_ANGLE;
      MODE_FBWA:  return axis == 2'd2 ? CTL_PASS : CTL_ANGLE;
      MODE_PROLL: return axis == 2'd0 ? CTL_ANGLE : CTL_PASS;
      default:    return CTL_PASS;
    endcase
  endfunction

  function automatic out_item_t pid_step(in_item_t s);
    out_item_t r;
    ctl_t      law;
    int        ax;
    longint    sp, err, raw, pv, iv, dv, asp;
    ax = int'(s.axis);
    pv = 0; iv = 0; dv = 0;
    if (s.throttle_zero)
      for (int a = 0; a < NUM_AXES; a++) m_integ[a] = 0;
    law = axis_law(m_mode, s.axis);
    r.axis_out = s.axis;
    if (law == CTL_PASS) begin
      if (ax < NUM_AXES) m_integ[ax] = 0;
      n_pass++;
      r.drive = s.stick;
    end else begin
      if (law == CTL_RATE) begin
        sp = (longint'(s.stick) * gain16(m_rates, ax)) >>> 7;
      end else begin
        asp = (longint'(s.stick) * gain16(m_angles, ax & 1)) >>> 7;
        sp = gain16(m_angles, 2) * (asp - longint'(s.attitude_angle));
      end
      err = sat_to(sp - longint'(s.gyro_rate), 24);
      pv = sat_to((gain16(m_kp, ax) * err) >>> GAIN_FRAC, 16);
      iv = m_integ[ax] + ((gain16(m_ki, ax) * err) >>> GAIN_FRAC);
      iv = iv > m_ilim ? m_ilim : (iv < -m_ilim ? -m_ilim : iv);
      m_integ[ax] = iv;
      raw = sat_to((gain16(m_kd, ax) * (err - m_last_err[ax])) >>> GAIN_FRAC, 24);
      m_dfilt[ax] += (m_alpha * (raw - m_dfilt[ax])) >>> 16;
      dv = sat_to(m_dfilt[ax], 16);
      m_last_err[ax] = err;
      r.drive = 16'(sat_to(pv + iv + dv, 16));
    end
    r.p_term = 16'(pv);
    r.i_term = 16'(iv);
    r.d_term = 16'(dv);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", n_results, what, got, want);
    errors++;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pid_results_q.push_back(pid_step(in_data));
        n_samples++;
      end
      if (!in_valid || in_ready) begin
        if (samples_q.size() > 0 && !tx_hold && (steady || $urandom_range(99) >= 38)) begin
          in_valid <= 1'b1;
          in_data <= samples_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || $urandom_range(99) >= 38;
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pid_results_q.size() == 0) begin
        report_mismatch("unexpected result count", pid_results_q.size() + 1, 0);
      end else begin
        want = pid_results_q.pop_front();
        if (out_data.axis_out != want.axis_out)
          report_mismatch("axis_out", out_data.axis_out, want.axis_out);
        if (out_data.drive != want.drive) report_mismatch("drive", out_data.drive, want.drive);
        if (out_data.p_term != want.p_term)
          report_mismatch("p_term", out_data.p_term, want.p_term);
        if (out_data.i_term != want.i_term)
          report_mismatch("i_term", out_data.i_term, want.i_term);
        if (out_data.d_term != want.d_term)
          report_mismatch("d_term", out_data.d_term, want.d_term);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || !rst_n || (samples_q.size() == 0 && pid_results_q.size() == 0 && !in_valid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_regs(reg_idx_t idx [$], logic [47:0] val [$]);
    for (int k = 0; k < idx.size(); k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
      n_cfg++;
      case (idx[k])
        REG_FLIGHT_MODE: if (val[k][2:0] <= 3'd4) m_mode = val[k][2:0];
        REG_PROP_GAINS:  m_kp = val[k];
        REG_INTEG_GAINS: m_ki = val[k];
        REG_DERIV_GAINS: m_kd = val[k];
        REG_RATE_LIMITS: m_rates = val[k];
        REG_ANGLE_SET:   m_angles = val[k];
        REG_INTEG_LIMIT: m_ilim = longint'(val[k][14:0]);
        REG_FILT_ALPHA:  m_alpha = longint'(val[k][15:0]);
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    wait (samples_q.size() == 0);
    do @(posedge clk); while (in_valid || pid_results_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [23:0] pick24();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(8191)) - 24'd4096;
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($urandom_range(1023)) - 24'd512;
    endcase
  endfunction

  function automatic in_item_t random_sample();
    in_item_t s;
    s.axis = 2'($urandom_range(3));
    case ($urandom_range(7))
      0: s.stick = 16'sh7FFF;
      1: s.stick = 16'sh8000;
      default: s.stick = 16'($urandom);
    endcase
    s.gyro_rate = pick24();
    s.attitude_angle = pick24();
    s.throttle_zero = $urandom_range(9) == 0;
    return s;
  endfunction

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  initial begin
    reg_idx_t    idx [$];
    logic [47:0] val [$];
    in_item_t    s;
    m_mode = MODE_RATE;
    {m_kp, m_ki, m_kd, m_rates, m_angles} = '0;
    m_ilim = 3277;
    m_alpha = 65535;
    for (int a = 0; a < 3; a++) begin
      m_integ[a] = 0; m_last_err[a] = 0; m_dfilt[a] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero gains, every axis
    for (int a = 0; a < 4; a++) begin
      s = '0;
      s.axis = 2'(a);
      s.stick = a[0] ? 16'sh7FFF : 16'sh8000;
      s.gyro_rate = a[1] ? 24'h7FFFFF : 24'h800000;
      s.attitude_angle = 24'h123456;
      samples_q.push_back(s);
    end
    drain();

    // extremes: full gains, then directed samples
    idx = '{REG_FLIGHT_MODE, REG_PROP_GAINS, REG_INTEG_GAINS, REG_DERIV_GAINS,
            REG_RATE_LIMITS, REG_ANGLE_SET, REG_INTEG_LIMIT, REG_FILT_ALPHA};
    val = '{48'd1, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
            48'h7FFF, 48'hFFFF};
    write_regs(idx, val);
    for (int k = 0; k < 16; k++) begin
      s.axis = 2'(k % 4);
      s.stick = k[2] ? 16'sh7FFF : (k[3] ? 16'sh8000 : 16'sh0000);
      s.gyro_rate = k[3] ? 24'h800000 : 24'h7FFFFF;
      s.attitude_angle = k[1] ? 24'h800000 : 24'h7FFFFF;
      s.throttle_zero = k == 9;
      samples_q.push_back(s);
    end
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      steady = ph == 5;
      idx = '{REG_FLIGHT_MODE, REG_FLIGHT_MODE, REG_PROP_GAINS, REG_INTEG_GAINS,
              REG_DERIV_GAINS, REG_RATE_LIMITS, REG_ANGLE_SET, REG_INTEG_LIMIT,
              REG_FILT_ALPHA};
      if (ph == 2)
        val = '{48'(ph % 5), 48'(5 + ph % 3), '0, '0, '0, '0, '0, '0, '0};
      else
        val = '{48'(ph % 5), 48'(5 + ph % 3), rand48(), rand48(), rand48(), rand48(),
                {16'($urandom_range(8)), 16'($urandom), 16'($urandom)},
                48'($urandom), 48'($urandom)};
      write_regs(idx, val);
      for (int k = 0; k < 42; k++) samples_q.push_back(random_sample());
      if (ph == 3) begin
        // hold the result side off so the core backs up
        rx_hold = 300;
      end
      drain();
    end

    $display("Covered %0d samples, %0d results, %0d passthrough, %0d register writes",
             n_samples, n_results, n_pass, n_cfg);
    $display("Flight modes rate to manual, ignored mode writes, zero and full-scale gains");
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/mafp_pkg.sv
rtl/mafp_ctrl.sv
rtl/mafp_datapath.sv
rtl/multi_axis_flight_pid_core.sv
dv/testbench.sv
